@@ src/wfr_pkg.sv @@
package wfr_pkg;

  // Parser phases, one per section of a frame, plus the halted state.
  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_PAYLOAD,
    PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_RSV,
    ERR_CTRL,
    ERR_SEQ,
    ERR_LONG
  } err_t;

  typedef enum logic [1:0] {
    KIND_TEXT,
    KIND_PING,
    KIND_CLOSE
  } kind_t;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

  localparam int MAX_LEN_W = 24;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = '1;

  localparam int MSG_COUNT_BITS_DEFAULT = 24;

  // Result queue between the parser and the output side.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    kind_t      kind;
    logic       last;
    err_t       error;
  } res_t;

  // Status from the parser to the top level.
  typedef struct packed {
    logic res_valid;
    logic halted;
  } pstat_t;

endpackage

@@ src/wfr_parser.sv @@
module wfr_parser #(
  parameter int MESSAGE_COUNT_BITS = wfr_pkg::MSG_COUNT_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  input  logic [7:0]                     rx_byte,
  input  logic [wfr_pkg::MAX_LEN_W-1:0]  max_len,
  output wfr_pkg::pstat_t                stat,
  output wfr_pkg::res_t                  res
);

  wfr_pkg::phase_t phase, phase_next;
  logic            frame_final, frame_final_next;
  logic [3:0]      frame_opcode, frame_opcode_next;
  logic [63:0]     payload_remaining, payload_remaining_next;
  logic [2:0]      ext_left, ext_left_next;
  logic [31:0]     mask_key, mask_key_next;
  logic [1:0]      mask_pos, mask_pos_next;
  logic            in_frag, in_frag_next;
  logic [MESSAGE_COUNT_BITS-1:0] message_used, message_used_next;

  logic [63:0] used_wide;
  logic [63:0] max_wide;
  logic [63:0] room;
  logic [7:0]  key_byte;
  logic        is_ctrl;
  logic        seq_bad;
  logic        res_valid;

  assign used_wide = 64'(message_used);
  assign max_wide  = 64'(max_len);
  assign room      = (used_wide > max_wide) ? 64'd0 : (max_wide - used_wide);
  assign is_ctrl   = frame_opcode[3];
  assign seq_bad   = ((frame_opcode == wfr_pkg::OP_CONT) && !in_frag) ||
                     (frame_opcode > wfr_pkg::OP_TEXT) ||
                     ((frame_opcode == wfr_pkg::OP_TEXT) && in_frag);

  always_comb begin
    case (mask_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    logic frame_end;
    phase_next             = phase;
    frame_final_next       = frame_final;
    frame_opcode_next      = frame_opcode;
    payload_remaining_next = payload_remaining;
    ext_left_next          = ext_left;
    mask_key_next          = mask_key;
    mask_pos_next          = mask_pos;
    in_frag_next           = in_frag;
    message_used_next      = message_used;
    res_valid              = 1'b0;
    res                    = '0;
    frame_end              = 1'b0;

    if (byte_valid) begin
      case (phase)
        wfr_pkg::PH_HDR0: begin
          if ((rx_byte & 8'h70) != 8'h00) begin
            phase_next = wfr_pkg::PH_HALT;
            res_valid  = 1'b1;
            res.error  = wfr_pkg::ERR_RSV;
          end else begin
            frame_final_next  = rx_byte[7];
            frame_opcode_next = rx_byte[3:0];
            phase_next        = wfr_pkg::PH_HDR1;
          end
        end
        wfr_pkg::PH_HDR1: begin
          if (!rx_byte[7]) begin
            phase_next = wfr_pkg::PH_HALT;
            res_valid  = 1'b1;
            res.error  = wfr_pkg::ERR_RSV;
          end else begin
            mask_key_next          = '0;
            mask_pos_next          = '0;
            payload_remaining_next = '0;
            if (rx_byte[6:0] == wfr_pkg::LEN7_EXT16) begin
              ext_left_next = 3'd1;
              phase_next    = wfr_pkg::PH_EXT;
            end else if (rx_byte[6:0] == wfr_pkg::LEN7_EXT64) begin
              ext_left_next = 3'd7;
              phase_next    = wfr_pkg::PH_EXT;
            end else begin
              payload_remaining_next = 64'(rx_byte[6:0]);
              phase_next             = wfr_pkg::PH_MASK;
            end
          end
        end
        wfr_pkg::PH_EXT: begin
          payload_remaining_next = {payload_remaining[55:0], rx_byte};
          if (ext_left == 3'd0) begin
            phase_next = wfr_pkg::PH_MASK;
          end else begin
            ext_left_next = ext_left - 3'd1;
          end
        end
        wfr_pkg::PH_MASK: begin
          mask_key_next = {mask_key[23:0], rx_byte};
          if (mask_pos != 2'd3) begin
            mask_pos_next = mask_pos + 2'd1;
          end else if (is_ctrl && (!frame_final ||
                       payload_remaining > wfr_pkg::CTRL_MAX_LEN)) begin
            phase_next = wfr_pkg::PH_HALT;
            res_valid  = 1'b1;
            res.error  = wfr_pkg::ERR_CTRL;
          end else if (!is_ctrl && seq_bad) begin
            phase_next = wfr_pkg::PH_HALT;
            res_valid  = 1'b1;
            res.error  = wfr_pkg::ERR_SEQ;
          end else if (!is_ctrl && (payload_remaining > room)) begin
            phase_next = wfr_pkg::PH_HALT;
            res_valid  = 1'b1;
            res.error  = wfr_pkg::ERR_LONG;
          end else begin
            mask_pos_next = '0;
            if (payload_remaining != 64'd0) begin
              phase_next = wfr_pkg::PH_PAYLOAD;
            end else begin
              frame_end = 1'b1;
              // An empty final text frame, close or ping still produces an end mark.
              if (!is_ctrl) begin
                res_valid = frame_final;
                res.kind  = wfr_pkg::KIND_TEXT;
                res.last  = 1'b1;
              end else if (frame_opcode == wfr_pkg::OP_CLOSE) begin
                res_valid = 1'b1;
                res.kind  = wfr_pkg::KIND_CLOSE;
                res.last  = 1'b1;
              end else if (frame_opcode == wfr_pkg::OP_PING) begin
                res_valid = 1'b1;
                res.kind  = wfr_pkg::KIND_PING;
                res.last  = 1'b1;
              end
            end
          end
        end
        wfr_pkg::PH_PAYLOAD: begin
          mask_pos_next          = mask_pos + 2'd1;
          payload_remaining_next = payload_remaining - 64'd1;
          frame_end              = (payload_remaining == 64'd1);
          res.data_byte          = rx_byte ^ key_byte;
          res.has_byte           = 1'b1;
          if (!is_ctrl) begin
            message_used_next = message_used + 1'b1;
            res_valid         = 1'b1;
            res.kind          = wfr_pkg::KIND_TEXT;
            res.last          = frame_end && frame_final;
          end else if (frame_opcode == wfr_pkg::OP_CLOSE) begin
            res_valid = 1'b1;
            res.kind  = wfr_pkg::KIND_CLOSE;
            res.last  = frame_end;
          end else if (frame_opcode == wfr_pkg::OP_PING) begin
            res_valid = 1'b1;
            res.kind  = wfr_pkg::KIND_PING;
            res.last  = frame_end;
          end
        end
        default: begin
        end
      endcase

      // End of a frame's payload: message bookkeeping and next phase.
      if (frame_end) begin
        if (!is_ctrl) begin
          if (frame_final) begin
            message_used_next = '0;
            in_frag_next      = 1'b0;
          end else begin
            in_frag_next = 1'b1;
          end
          phase_next = wfr_pkg::PH_HDR0;
        end else if (frame_opcode == wfr_pkg::OP_CLOSE) begin
          phase_next = wfr_pkg::PH_HALT;
        end else begin
          phase_next = wfr_pkg::PH_HDR0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= wfr_pkg::PH_HDR0;
      in_frag      <= 1'b0;
      message_used <= '0;
    end else begin
      phase        <= phase_next;
      in_frag      <= in_frag_next;
      message_used <= message_used_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_final       <= frame_final_next;
    frame_opcode      <= frame_opcode_next;
    payload_remaining <= payload_remaining_next;
    ext_left          <= ext_left_next;
    mask_key          <= mask_key_next;
    mask_pos          <= mask_pos_next;
  end

  assign stat.res_valid = res_valid;
  assign stat.halted    = (phase == wfr_pkg::PH_HALT);

endmodule

@@ src/wfr_fifo.sv @@
module wfr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  wfr_pkg::res_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output wfr_pkg::res_t rd_data,
  output logic          empty
);

  wfr_pkg::res_t mem [wfr_pkg::QDEPTH];
  logic [wfr_pkg::QPTR_W-1:0] wr_ptr;
  logic [wfr_pkg::QPTR_W-1:0] rd_ptr;
  logic [wfr_pkg::QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_data = mem[rd_ptr];
  assign empty   = (count == '0);
  assign full    = (count == wfr_pkg::QCNT_W'(wfr_pkg::QDEPTH));

endmodule

@@ src/websocket_frame_receiver.sv @@
// WebSocket frame receiver for the client-to-server direction.
// The input side is a queue: present one received byte on rx_byte and raise
// push; the transaction completes at a clock edge where full is low. The
// result side is also a queue: while empty is low the oldest result sits on
// data_byte, has_byte, kind, last and error, and a pop with empty low takes it.
// Each byte produces zero or one result; header bytes mostly produce none.
// A result enters the result queue at the clock edge of its byte's transaction,
// and the parser takes one byte every cycle as long as full stays low. The
// parser updates its state once per accepted byte; a four-entry result
// queue separates it from the consumer, so a stalled consumer only stops input
// once four results wait, at which point full rises.
// The limit register max_message_length is written through cfg_write and
// cfg_data and should only change while the stream is quiet.
// Reset clears the parser to expect a frame header, empties the result queue
// and sets the limit to its largest value. After an error result or the end
// of a close frame the parser ignores every further byte until reset.
module websocket_frame_receiver #(
  parameter int MESSAGE_COUNT_BITS = wfr_pkg::MSG_COUNT_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    rx_byte,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    data_byte,
  output logic                          has_byte,
  output logic [1:0]                    kind,
  output logic                          last,
  output logic [2:0]                    error,
  input  logic                          cfg_write,
  input  logic [wfr_pkg::MAX_LEN_W-1:0] cfg_data
);

  logic [wfr_pkg::MAX_LEN_W-1:0] max_message_length;
  logic            byte_accept;
  logic            res_accept;
  wfr_pkg::pstat_t pstat;
  wfr_pkg::res_t   parser_res;
  wfr_pkg::res_t   head;

  // The limit register; no read-back is provided.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_message_length <= wfr_pkg::MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_message_length <= cfg_data;
    end
  end

  assign byte_accept = push && !full;
  assign res_accept  = pop && !empty;

  // Front part: header parsing, protocol checks and unmasking.
  wfr_parser #(
    .MESSAGE_COUNT_BITS(MESSAGE_COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_accept),
    .rx_byte   (rx_byte),
    .max_len   (max_message_length),
    .stat      (pstat),
    .res       (parser_res)
  );

  // Back part: the result queue that feeds the output transactions.
  wfr_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (byte_accept && pstat.res_valid),
    .wr_data(parser_res),
    .full   (full),
    .rd_en  (res_accept),
    .rd_data(head),
    .empty  (empty)
  );

  assign data_byte = head.data_byte;
  assign has_byte  = head.has_byte;
  assign kind      = head.kind;
  assign last      = head.last;
  assign error     = head.error;

  // Once halted, the parser stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    pstat.halted |=> pstat.halted)
    else $error("parser left the halted state without reset");

  // A halted parser never produces another result.
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    pstat.halted |-> !pstat.res_valid)
    else $error("result produced while halted");

  // Error results carry no byte, no end mark and kind zero.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && (error != wfr_pkg::ERR_NONE)) |->
      (!has_byte && !last && (kind == wfr_pkg::KIND_TEXT)))
    else $error("malformed error result");

  // A result without a byte shows a zero data byte.
  a_nobyte_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !has_byte) |-> (data_byte == 8'd0))
    else $error("data byte set without has_byte");

endmodule

@@ test/tb_websocket_frame_receiver.sv @@
module tb_websocket_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import wfr_pkg::*;

  // Opcodes and length encodings that the package does not name.
  localparam logic [3:0] OP_BINARY   = 4'h2;
  localparam logic [3:0] OP_DATA_TOP = 4'h7;
  localparam logic [3:0] OP_PONG     = 4'hA;
  localparam logic [3:0] OP_CTRL_TOP = 4'hF;

  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 150;
  localparam int CYCLE_LIMIT   = 400000;

  // The ways the run may bring the parser to its halted state. Only one of
  // them can happen per run, since reset is applied once.
  typedef enum int {
    END_RSV,
    END_MASK_CLEAR,
    END_CTRL_FRAG,
    END_CTRL_LONG,
    END_BAD_SEQ,
    END_TOO_LONG,
    END_CLOSE
  } ending_t;

  // Tracks the deframer state and keeps the results that the bytes seen so
  // far must produce, oldest first.
  class deframe_scoreboard;
    phase_t                        phase;
    bit                            frame_fin;
    logic [3:0]                    opcode;
    logic [63:0]                   remaining;
    logic [2:0]                    ext_left;
    logic [31:0]                   key;
    logic [1:0]                    key_pos;
    bit                            in_frag;
    logic [MSG_COUNT_BITS_DEFAULT-1:0] used;
    logic [MAX_LEN_W-1:0]          limit;
    res_t                          outputs_due[$];
    int                            mismatches;

    function new();
      phase      = PH_HDR0;
      frame_fin  = 1'b0;
      opcode     = OP_CONT;
      remaining  = '0;
      ext_left   = '0;
      key        = '0;
      key_pos    = '0;
      in_frag    = 1'b0;
      used       = '0;
      limit      = MAX_LEN_RESET;
      mismatches = 0;
    endfunction

    function void set_limit(logic [MAX_LEN_W-1:0] value);
      limit = value;
    endfunction

    function void emit(logic [7:0] d, logic has, kind_t k, logic l, err_t e);
      res_t r;
      r.data_byte = d;
      r.has_byte  = has;
      r.kind      = k;
      r.last      = l;
      r.error     = e;
      outputs_due.push_back(r);
    endfunction

    function void halt_with(err_t e);
      phase = PH_HALT;
      emit(8'h00, 1'b0, KIND_TEXT, 1'b0, e);
    endfunction

    function void finish_frame();
      if (opcode < OP_CLOSE) begin
        if (frame_fin) begin
          used    = '0;
          in_frag = 1'b0;
        end else begin
          in_frag = 1'b1;
        end
        phase = PH_HDR0;
      end else if (opcode == OP_CLOSE) begin
        phase = PH_HALT;
      end else begin
        phase = PH_HDR0;
      end
    endfunction

    // The frame checks run once the last key byte is in and the length is
    // final.
    function void header_complete();
      logic [63:0] room;
      if (opcode >= OP_CLOSE) begin
        if (!frame_fin || remaining > CTRL_MAX_LEN) begin
          halt_with(ERR_CTRL);
          return;
        end
      end else begin
        if ((opcode == OP_CONT && !in_frag) || opcode > OP_TEXT ||
            (opcode == OP_TEXT && in_frag)) begin
          halt_with(ERR_SEQ);
          return;
        end
        room = (used > limit) ? 64'd0 : 64'(limit) - 64'(used);
        if (remaining > room) begin
          halt_with(ERR_LONG);
          return;
        end
      end
      key_pos = '0;
      if (remaining != 0) begin
        phase = PH_PAYLOAD;
        return;
      end
      finish_frame();
      if (opcode < OP_CLOSE) begin
        if (frame_fin) emit(8'h00, 1'b0, KIND_TEXT, 1'b1, ERR_NONE);
      end else if (opcode == OP_CLOSE) begin
        emit(8'h00, 1'b0, KIND_CLOSE, 1'b1, ERR_NONE);
      end else if (opcode == OP_PING) begin
        emit(8'h00, 1'b0, KIND_PING, 1'b1, ERR_NONE);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0] plain;
      int         shift;
      bit         done;
      case (phase)
        PH_HDR0: begin
          if (b[6:4] != 3'b000) begin
            halt_with(ERR_RSV);
          end else begin
            frame_fin = b[7];
            opcode    = b[3:0];
            phase     = PH_HDR1;
          end
        end
        PH_HDR1: begin
          if (!b[7]) begin
            halt_with(ERR_RSV);
          end else begin
            key       = '0;
            key_pos   = '0;
            remaining = '0;
            if (b[6:0] == LEN7_EXT16) begin
              ext_left = 3'd1;
              phase    = PH_EXT;
            end else if (b[6:0] == LEN7_EXT64) begin
              ext_left = 3'd7;
              phase    = PH_EXT;
            end else begin
              remaining = 64'(b[6:0]);
              phase     = PH_MASK;
            end
          end
        end
        PH_EXT: begin
          remaining = {remaining[55:0], b};
          if (ext_left == 0) phase = PH_MASK;
          else ext_left = ext_left - 3'd1;
        end
        PH_MASK: begin
          key = {key[23:0], b};
          if (key_pos == 2'd3) header_complete();
          else key_pos = key_pos + 2'd1;
        end
        PH_PAYLOAD: begin
          shift     = 8 * (3 - int'(key_pos));
          plain     = b ^ key[shift +: 8];
          key_pos   = key_pos + 2'd1;
          remaining = remaining - 64'd1;
          done      = (remaining == 0);
          if (opcode < OP_CLOSE) used = used + 1'b1;
          if (done) finish_frame();
          if (opcode < OP_CLOSE) begin
            emit(plain, 1'b1, KIND_TEXT, done && frame_fin, ERR_NONE);
          end else if (opcode == OP_CLOSE) begin
            emit(plain, 1'b1, KIND_CLOSE, done, ERR_NONE);
          end else if (opcode == OP_PING) begin
            emit(plain, 1'b1, KIND_PING, done, ERR_NONE);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_output(res_t got);
      res_t want;
      if (outputs_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected nothing, actual %0h",
                 $time, got);
        return;
      end
      want = outputs_due.pop_front();
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("has_byte", want.has_byte, got.has_byte);
      compare_field("kind", want.kind, got.kind);
      compare_field("last", want.last, got.last);
      compare_field("error", want.error, got.error);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [7:0]           rx_byte = 8'h00;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [7:0]           data_byte;
  logic                 has_byte;
  logic [1:0]           kind;
  logic                 last;
  logic [2:0]           error;
  logic                 cfg_write = 1'b0;
  logic [MAX_LEN_W-1:0] cfg_data = '0;

  deframe_scoreboard sb = new();

  // Stimulus bookkeeping: the sender keeps its own view of the message in
  // progress so that the random traffic stays legal.
  bit          frag_open = 1'b0;
  logic [63:0] msg_len = '0;
  logic [63:0] cur_limit = 64'(MAX_LEN_RESET);
  bit          sender_steady = 1'b0;
  bit          hold_request = 1'b0;
  int          cycle_count = 0;

  websocket_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .rx_byte   (rx_byte),
    .empty     (empty),
    .pop       (pop),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .kind      (kind),
    .last      (last),
    .error     (error),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a stuck handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Both handshakes are observed at the clock edge, with the values that the
  // block itself sees there. A result is checked before the byte of the same edge
  // is noted; results go through the registered queue, so the two never interact.
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      sb.check_output(res_t'({data_byte, has_byte, kind, last, error}));
    if (!rst && push && !full)
      sb.note_byte(rx_byte);
  end

  // Result side. Each transaction is preceded by a random wait, with
  // occasional stretches of back-to-back pops. On request it holds off for a
  // long time so that the result queue fills and full rises.
  initial begin : result_drain
    int gap;
    bit steady;
    steady = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) steady = !steady;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        pop <= 1'b1;
        do @(posedge clk); while (empty);
      end
    end
  end

  // Offers one byte after a random gap and returns at the edge where the
  // transaction completes, with push still high so that a following byte
  // can go out without a bubble.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 63) == 0) sender_steady = !sender_steady;
    gap = sender_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
  endtask

  // Drops push and waits until every expected result has been taken, then lets
  // the block settle, since header bytes produce nothing that could be seen.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (sb.outputs_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [MAX_LEN_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_limit(value);
    cur_limit = 64'(value);
    cfg_write <= 1'b0;
  endtask

  // Picks a length encoding; short lengths sometimes go out in a longer,
  // non-minimal form.
  function automatic int pick_form(logic [63:0] len);
    int r;
    r = $urandom_range(0, 7);
    if (len > 64'd65535) return FORM_EXT64;
    if (len >= 64'd126) return (r < 4) ? FORM_EXT16 : FORM_EXT64;
    if (r < 6) return FORM_SHORT;
    return (r == 6) ? FORM_EXT16 : FORM_EXT64;
  endfunction

  function automatic logic [63:0] ctrl_len();
    if ($urandom_range(0, 15) == 0) return CTRL_MAX_LEN;
    return 64'($urandom_range(0, 8));
  endfunction

  // Both header bytes, the extended length if any, and the masking key.
  task automatic send_header(input bit fin, input logic [3:0] op, input logic [63:0] len,
                             input int form, input logic [31:0] mask);
    int i;
    send_byte({fin, 3'b000, op});
    case (form)
      FORM_SHORT: send_byte({1'b1, len[6:0]});
      FORM_EXT16: begin
        send_byte({1'b1, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({1'b1, LEN7_EXT64});
        for (i = 7; i >= 0; i--) send_byte(len[i*8 +: 8]);
      end
    endcase
    for (i = 3; i >= 0; i--) send_byte(mask[i*8 +: 8]);
  endtask

  task automatic send_frame(input bit fin, input logic [3:0] op, input logic [63:0] len,
                            input int form);
    send_header(fin, op, len, form, $urandom());
    repeat (int'(len)) send_byte(8'($urandom()));
  endtask

  // A text or continuation frame, whichever is legal next, trimmed so that
  // the message stays within the current limit.
  task automatic send_data(input bit fin, input logic [63:0] want_len, input int form);
    logic [63:0] room;
    logic [63:0] len;
    room = (msg_len >= cur_limit) ? 64'd0 : cur_limit - msg_len;
    len  = (want_len > room) ? room : want_len;
    send_frame(fin, frag_open ? OP_CONT : OP_TEXT, len, form);
    if (fin) begin
      frag_open = 1'b0;
      msg_len   = '0;
    end else begin
      frag_open = 1'b1;
      msg_len   = msg_len + len;
    end
  endtask

  // Well-formed traffic: text messages, often fragmented, with pings, pongs
  // and reserved control frames mixed in, also between fragments.
  task automatic random_traffic(input int frames);
    int          pick;
    logic [63:0] len;
    repeat (frames) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        case ($urandom_range(0, 31))
          0:       len = 64'($urandom_range(126, 300));
          1, 2, 3: len = 64'd0;
          default: len = 64'($urandom_range(1, 12));
        endcase
        send_data($urandom_range(0, 2) != 0, len, pick_form(len));
      end else if (pick < 8) begin
        len = ctrl_len();
        send_frame(1'b1, OP_PING, len, pick_form(len));
      end else begin
        len = ctrl_len();
        send_frame(1'b1, 4'($urandom_range(OP_PONG, OP_CTRL_TOP)), len, pick_form(len));
      end
    end
  endtask

  initial begin : stream_source
    ending_t     ending;
    logic [63:0] len;
    logic [63:0] room;
    logic [3:0]  op;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, limit at its reset value. An empty final text frame
    // gives a bare end marker.
    send_data(1'b1, 64'd0, FORM_SHORT);
    // All-zero and all-one key with all-zero and all-one payload bytes.
    send_header(1'b1, OP_TEXT, 64'd2, FORM_SHORT, 32'h0000_0000);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(1'b1, OP_PING, 64'd2, FORM_EXT16, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    // Empty ping, then a pong and a reserved control frame, which are
    // swallowed; the pong uses a non-minimal 64-bit length.
    send_frame(1'b1, OP_PING, 64'd0, FORM_SHORT);
    send_frame(1'b1, OP_PONG, 64'd3, FORM_EXT64);
    send_frame(1'b1, OP_CTRL_TOP, 64'd1, FORM_SHORT);
    // Fragmented message with a ping in the middle and an empty non-final
    // continuation, which must produce nothing.
    send_data(1'b0, 64'd3, FORM_SHORT);
    send_frame(1'b1, OP_PING, 64'd1, FORM_SHORT);
    send_data(1'b0, 64'd0, FORM_SHORT);
    send_data(1'b1, 64'd2, FORM_EXT64);
    wait_drained();

    // Zero limit: only empty text frames get through; a ping is not limited.
    write_limit('0);
    send_data(1'b1, 64'd0, FORM_SHORT);
    send_data(1'b0, 64'd0, FORM_SHORT);
    send_data(1'b1, 64'd0, FORM_EXT16);
    send_frame(1'b1, OP_PING, 64'd1, FORM_SHORT);
    wait_drained();

    // A message that fills the limit exactly, then a limit lowered below
    // what the open message already holds, closed by an empty continuation.
    write_limit(MAX_LEN_W'(40));
    send_data(1'b0, 64'd30, FORM_SHORT);
    send_data(1'b1, 64'd10, FORM_SHORT);
    send_data(1'b0, 64'd20, FORM_SHORT);
    wait_drained();
    write_limit(MAX_LEN_W'(5));
    send_data(1'b1, 64'd0, FORM_SHORT);
    wait_drained();

    // Random part across several limits.
    write_limit(MAX_LEN_RESET);
    random_traffic(18);
    wait_drained();
    write_limit(MAX_LEN_W'($urandom_range(20, 400)));
    random_traffic(18);
    wait_drained();
    write_limit(MAX_LEN_RESET);

    // Back pressure: the receiver stops for a long stretch while a long
    // message is offered, so the block must stall its input.
    hold_request = 1'b1;
    send_data(1'b1, 64'd40, FORM_SHORT);
    random_traffic(6);
    wait_drained();

    // Exactly one way into the halted state per run, picked at random.
    ending = ending_t'($urandom_range(0, 6));
    case (ending)
      END_RSV: begin
        send_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                   4'($urandom_range(0, 15))});
      end
      END_MASK_CLEAR: begin
        send_byte({1'b1, 3'b000, OP_PING});
        send_byte({1'b0, 7'($urandom_range(0, 127))});
      end
      END_CTRL_FRAG: begin
        len = ctrl_len();
        send_header(1'b0, OP_PING, len, pick_form(len), $urandom());
      end
      END_CTRL_LONG: begin
        if ($urandom_range(0, 1) != 0) len = 64'($urandom_range(126, 70000));
        else len = {1'b1, 31'($urandom()), 32'($urandom())};
        send_header(1'b1, 4'($urandom_range(OP_CLOSE, OP_CTRL_TOP)), len,
                    pick_form(len), $urandom());
      end
      END_BAD_SEQ: begin
        if ($urandom_range(0, 2) == 0) op = frag_open ? OP_TEXT : OP_CONT;
        else op = 4'($urandom_range(OP_BINARY, OP_DATA_TOP));
        len = 64'($urandom_range(0, 4));
        send_header(1'($urandom_range(0, 1)), op, len, pick_form(len), $urandom());
      end
      END_TOO_LONG: begin
        // When a fragment is open this may also set the limit below what the
        // message already used.
        write_limit(MAX_LEN_W'($urandom_range(0, 30)));
        room = (msg_len >= cur_limit) ? 64'd0 : cur_limit - msg_len;
        len  = room + 64'($urandom_range(1, 4));
        send_header(1'($urandom_range(0, 1)), frag_open ? OP_CONT : OP_TEXT, len,
                    pick_form(len), $urandom());
      end
      default: begin
        len = ctrl_len();
        send_frame(1'b1, OP_CLOSE, len, pick_form(len));
      end
    endcase
    // Once halted, every byte must be ignored.
    repeat (20) send_byte(8'($urandom()));
    wait_drained();

    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
